// ===== rtl/core/ctp_pkg.sv =====
// Types, widths and stage functions for the three-point circle pipeline.
// Used by circle_through_three_points; depends on nothing else.
package ctp_pkg;

   localparam int CoordBits = 16;
   localparam int RootBits  = 55;
   localparam int RadBits   = 2 * RootBits;
   localparam int QBits     = 33;
   localparam int DivdBits  = 58;
   localparam int DvsrBits  = 37;

   typedef struct packed {
      logic signed [CoordBits-1:0] first_x;
      logic signed [CoordBits-1:0] first_y;
      logic signed [CoordBits-1:0] second_x;
      logic signed [CoordBits-1:0] second_y;
      logic signed [CoordBits-1:0] third_x;
      logic signed [CoordBits-1:0] third_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] centre_x;
      logic signed [31:0] centre_y;
      logic [31:0]        radius;
      logic               valid_res;
      logic               clipped;
   } rsp_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] x1;
      logic signed [CoordBits-1:0] y1;
      logic [34:0]                 aw;
      logic                        zero;
      logic                        negx;
      logic                        negy;
   } side_type;

   typedef struct packed {
      logic [DvsrBits-1:0] rem;
      logic [QBits-1:0]    dlo;
      logic [QBits-1:0]    q;
      logic [DvsrBits-1:0] e;
      logic                ovf;
   } div_type;

   typedef struct packed {
      logic [RootBits+2:0]  rem;
      logic [RootBits-1:0]  root;
      logic [RadBits-1:0]   rad;
   } sqrt_type;

   typedef struct packed {
      logic     vld;
      side_type side;
      sqrt_type sq;
      div_type  cx;
      div_type  cy;
      div_type  dr;
   } stage_type;

   function automatic div_type div_init(logic [DivdBits-1:0] d, logic [DvsrBits-1:0] e);
      div_type r;
      r.rem = DvsrBits'(d[DivdBits-1:QBits]);
      r.dlo = d[QBits-1:0];
      r.q   = '0;
      r.e   = e;
      r.ovf = (DvsrBits'(d[DivdBits-1:QBits]) >= e);
      return r;
   endfunction

   function automatic div_type div_step(div_type d);
      div_type           r;
      logic [DvsrBits:0] t;
      logic              hit;
      r   = d;
      t   = {d.rem, d.dlo[QBits-1]};
      hit = (t >= {1'b0, d.e});
      if (hit) begin
         r.rem = DvsrBits'(t - {1'b0, d.e});
      end else begin
         r.rem = t[DvsrBits-1:0];
      end
      r.dlo = {d.dlo[QBits-2:0], 1'b0};
      r.q   = {d.q[QBits-2:0], hit};
      return r;
   endfunction

   function automatic sqrt_type sqrt_step(sqrt_type s);
      sqrt_type            r;
      logic [RootBits+2:0] t;
      logic [RootBits+2:0] trial;
      t     = {s.rem[RootBits:0], s.rad[RadBits-1:RadBits-2]};
      trial = {1'b0, s.root, 2'b01};
      r.rad = {s.rad[RadBits-3:0], 2'b00};
      if (t >= trial) begin
         r.rem  = t - trial;
         r.root = {s.root[RootBits-2:0], 1'b1};
      end else begin
         r.rem  = t;
         r.root = {s.root[RootBits-2:0], 1'b0};
      end
      return r;
   endfunction

   // {clip, value}: round-half-away quotient with sign, saturated to 32 bits
   function automatic logic [32:0] centre_out(div_type d, logic neg);
      logic        clip;
      logic [31:0] val;
      if (neg) begin
         clip = d.ovf | d.q[32] | (d.q[31] & (|d.q[30:0]));
         val  = clip ? 32'h8000_0000 : 32'(32'd0 - d.q[31:0]);
      end else begin
         clip = d.ovf | d.q[32] | d.q[31];
         val  = clip ? 32'h7FFF_FFFF : d.q[31:0];
      end
      return {clip, val};
   endfunction

endpackage

// ===== rtl/core/circle_through_three_points.sv =====
// One request is accepted per cycle while no held result is waiting on rsp_ready.
// Depth is set by the 55-step square root followed by the 33-step radius
// division; the two centre divisions run beside the square root.
// A stalled result freezes the whole pipeline. Reset clears all valid bits;
// data registers are not reset.
// Top level of the three-point circle unit; depends on ctp_pkg.
module circle_through_three_points (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ctp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ctp_pkg::rsp_type rsp_data
);

   localparam int SqSteps  = ctp_pkg::RootBits;
   localparam int DivSteps = ctp_pkg::QBits;
   localparam int Last     = SqSteps + DivSteps + 1;

   typedef struct packed {
      logic vld;
      logic signed [16:0] a1, b1, a2, b2, sx1, sy1, sx2, sy2;
      logic signed [15:0] x1, y1;
   } s1_type;

   typedef struct packed {
      logic vld;
      logic signed [33:0] p1, p2, p3, p4, p5, p6;
      logic signed [16:0] a1, b1, a2, b2;
      logic signed [15:0] x1, y1;
   } s2_type;

   typedef struct packed {
      logic vld;
      logic signed [35:0] c1, c2, w;
      logic signed [16:0] a1, b1, a2, b2;
      logic signed [15:0] x1, y1;
   } s3_type;

   typedef struct packed {
      logic vld;
      logic signed [53:0] m1, m2, m3, m4, xw, yw;
      logic signed [35:0] w;
      logic signed [15:0] x1, y1;
   } s4_type;

   typedef struct packed {
      logic vld;
      logic signed [53:0] nx, ny, xw, yw;
      logic signed [35:0] w;
      logic signed [15:0] x1, y1;
   } s5_type;

   typedef struct packed {
      logic vld;
      logic signed [55:0] dx, dy;
      ctp_pkg::side_type  side;
      ctp_pkg::div_type   cx, cy;
   } s6_type;

   typedef struct packed {
      logic vld;
      logic [53:0]       adx, ady;
      ctp_pkg::side_type side;
      ctp_pkg::div_type  cx, cy;
   } s7_type;

   typedef struct packed {
      logic vld;
      logic [53:0]       xhh, xhl, xll, yhh, yhl, yll;
      ctp_pkg::side_type side;
      ctp_pkg::div_type  cx, cy;
   } s8_type;

   typedef struct packed {
      logic vld;
      logic [107:0]      sqx, sqy;
      ctp_pkg::side_type side;
      ctp_pkg::div_type  cx, cy;
   } s9_type;

   logic adv;
   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   s6_type s6_in, s6_ff;
   s7_type s7_in, s7_ff;
   s8_type s8_in, s8_ff;
   s9_type s9_in, s9_ff;
   ctp_pkg::stage_type ch_in [0:Last];
   ctp_pkg::stage_type ch_ff [0:Last];
   logic               rsp_valid_in, rsp_valid_ff;
   ctp_pkg::rsp_type   rsp_data_in, rsp_data_ff;

   logic signed [35:0] v3;
   logic [53:0]        anx, any;
   logic [34:0]        aw6;
   logic [32:0]        cxo, cyo;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // differences and sums
   always_comb begin
      s1_in.vld = req_valid;
      s1_in.a1  = req_data.second_x - req_data.first_x;
      s1_in.b1  = req_data.second_y - req_data.first_y;
      s1_in.a2  = req_data.third_x - req_data.second_x;
      s1_in.b2  = req_data.third_y - req_data.second_y;
      s1_in.sx1 = req_data.second_x + req_data.first_x;
      s1_in.sy1 = req_data.second_y + req_data.first_y;
      s1_in.sx2 = req_data.third_x + req_data.second_x;
      s1_in.sy2 = req_data.third_y + req_data.second_y;
      s1_in.x1  = req_data.second_x;
      s1_in.y1  = req_data.second_y;
   end

   always_comb begin
      s2_in.vld = s1_ff.vld;
      s2_in.p1  = s1_ff.sx1 * s1_ff.a1;
      s2_in.p2  = s1_ff.sy1 * s1_ff.b1;
      s2_in.p3  = s1_ff.sx2 * s1_ff.a2;
      s2_in.p4  = s1_ff.sy2 * s1_ff.b2;
      s2_in.p5  = s1_ff.a2 * s1_ff.b1;
      s2_in.p6  = s1_ff.a1 * s1_ff.b2;
      s2_in.a1  = s1_ff.a1;
      s2_in.b1  = s1_ff.b1;
      s2_in.a2  = s1_ff.a2;
      s2_in.b2  = s1_ff.b2;
      s2_in.x1  = s1_ff.x1;
      s2_in.y1  = s1_ff.y1;
   end

   always_comb begin
      v3        = s2_ff.p5 - s2_ff.p6;
      s3_in.vld = s2_ff.vld;
      s3_in.c1  = -(s2_ff.p1 + s2_ff.p2);
      s3_in.c2  = -(s2_ff.p3 + s2_ff.p4);
      s3_in.w   = v3 <<< 1;
      s3_in.a1  = s2_ff.a1;
      s3_in.b1  = s2_ff.b1;
      s3_in.a2  = s2_ff.a2;
      s3_in.b2  = s2_ff.b2;
      s3_in.x1  = s2_ff.x1;
      s3_in.y1  = s2_ff.y1;
   end

   always_comb begin
      s4_in.vld = s3_ff.vld;
      s4_in.m1  = s3_ff.b2 * s3_ff.c1;
      s4_in.m2  = s3_ff.b1 * s3_ff.c2;
      s4_in.m3  = s3_ff.a1 * s3_ff.c2;
      s4_in.m4  = s3_ff.a2 * s3_ff.c1;
      s4_in.xw  = s3_ff.x1 * s3_ff.w;
      s4_in.yw  = s3_ff.y1 * s3_ff.w;
      s4_in.w   = s3_ff.w;
      s4_in.x1  = s3_ff.x1;
      s4_in.y1  = s3_ff.y1;
   end

   always_comb begin
      s5_in.vld = s4_ff.vld;
      s5_in.nx  = s4_ff.m1 - s4_ff.m2;
      s5_in.ny  = s4_ff.m3 - s4_ff.m4;
      s5_in.xw  = s4_ff.xw;
      s5_in.yw  = s4_ff.yw;
      s5_in.w   = s4_ff.w;
      s5_in.x1  = s4_ff.x1;
      s5_in.y1  = s4_ff.y1;
   end

   // set up the centre divisions
   always_comb begin
      anx            = s5_ff.nx[53] ? 54'(-s5_ff.nx) : 54'(s5_ff.nx);
      any            = s5_ff.ny[53] ? 54'(-s5_ff.ny) : 54'(s5_ff.ny);
      aw6            = s5_ff.w[35] ? 35'(-s5_ff.w) : 35'(s5_ff.w);
      s6_in.vld      = s5_ff.vld;
      s6_in.dx       = s5_ff.xw - s5_ff.nx;
      s6_in.dy       = s5_ff.yw - s5_ff.ny;
      s6_in.side.x1   = s5_ff.x1;
      s6_in.side.y1   = s5_ff.y1;
      s6_in.side.aw   = aw6;
      s6_in.side.zero = (s5_ff.w == '0);
      s6_in.side.negx = s5_ff.nx[53] ^ s5_ff.w[35];
      s6_in.side.negy = s5_ff.ny[53] ^ s5_ff.w[35];
      s6_in.cx = ctp_pkg::div_init(ctp_pkg::DivdBits'({anx, 1'b0}) + ctp_pkg::DivdBits'(aw6),
                                   ctp_pkg::DvsrBits'({aw6, 1'b0}));
      s6_in.cy = ctp_pkg::div_init(ctp_pkg::DivdBits'({any, 1'b0}) + ctp_pkg::DivdBits'(aw6),
                                   ctp_pkg::DvsrBits'({aw6, 1'b0}));
   end

   always_comb begin
      s7_in.vld  = s6_ff.vld;
      s7_in.adx  = s6_ff.dx[55] ? 54'(-s6_ff.dx) : 54'(s6_ff.dx);
      s7_in.ady  = s6_ff.dy[55] ? 54'(-s6_ff.dy) : 54'(s6_ff.dy);
      s7_in.side = s6_ff.side;
      s7_in.cx   = s6_ff.cx;
      s7_in.cy   = s6_ff.cy;
   end

   // split squares into 27-bit partial products
   always_comb begin
      s8_in.vld  = s7_ff.vld;
      s8_in.xhh  = s7_ff.adx[53:27] * s7_ff.adx[53:27];
      s8_in.xhl  = s7_ff.adx[53:27] * s7_ff.adx[26:0];
      s8_in.xll  = s7_ff.adx[26:0] * s7_ff.adx[26:0];
      s8_in.yhh  = s7_ff.ady[53:27] * s7_ff.ady[53:27];
      s8_in.yhl  = s7_ff.ady[53:27] * s7_ff.ady[26:0];
      s8_in.yll  = s7_ff.ady[26:0] * s7_ff.ady[26:0];
      s8_in.side = s7_ff.side;
      s8_in.cx   = s7_ff.cx;
      s8_in.cy   = s7_ff.cy;
   end

   always_comb begin
      s9_in.vld  = s8_ff.vld;
      s9_in.sqx  = {s8_ff.xhh, 54'd0} + 108'({s8_ff.xhl, 28'd0}) + 108'(s8_ff.xll);
      s9_in.sqy  = {s8_ff.yhh, 54'd0} + 108'({s8_ff.yhl, 28'd0}) + 108'(s8_ff.yll);
      s9_in.side = s8_ff.side;
      s9_in.cx   = s8_ff.cx;
      s9_in.cy   = s8_ff.cy;
   end

   always_comb begin
      ch_in[0].vld     = s9_ff.vld;
      ch_in[0].side    = s9_ff.side;
      ch_in[0].sq.rem  = '0;
      ch_in[0].sq.root = '0;
      ch_in[0].sq.rad  = {108'(s9_ff.sqx + s9_ff.sqy), 2'b00};
      ch_in[0].cx      = s9_ff.cx;
      ch_in[0].cy      = s9_ff.cy;
      ch_in[0].dr      = '0;
   end

   // root steps with centre division beside them, then radius division
   for (genvar k = 0; k < Last; k++) begin : g_ch
      always_comb begin
         ch_in[k+1] = ch_ff[k];
         if (k < SqSteps) begin
            ch_in[k+1].sq = ctp_pkg::sqrt_step(ch_ff[k].sq);
         end
         if (k < DivSteps) begin
            ch_in[k+1].cx = ctp_pkg::div_step(ch_ff[k].cx);
            ch_in[k+1].cy = ctp_pkg::div_step(ch_ff[k].cy);
         end
         if (k == SqSteps) begin
            ch_in[k+1].dr = ctp_pkg::div_init(
               ctp_pkg::DivdBits'(ch_ff[k].sq.root) + ctp_pkg::DivdBits'(ch_ff[k].side.aw),
               ctp_pkg::DvsrBits'({ch_ff[k].side.aw, 1'b0}));
         end
         if (k > SqSteps) begin
            ch_in[k+1].dr = ctp_pkg::div_step(ch_ff[k].dr);
         end
      end
   end

   // format, saturate, pick the collinear fallback
   always_comb begin
      cxo          = ctp_pkg::centre_out(ch_ff[Last].cx, ch_ff[Last].side.negx);
      cyo          = ctp_pkg::centre_out(ch_ff[Last].cy, ch_ff[Last].side.negy);
      rsp_valid_in = ch_ff[Last].vld;
      if (ch_ff[Last].side.zero) begin
         rsp_data_in.centre_x  = 32'(ch_ff[Last].side.x1);
         rsp_data_in.centre_y  = 32'(ch_ff[Last].side.y1);
         rsp_data_in.radius    = '0;
         rsp_data_in.valid_res = 1'b0;
         rsp_data_in.clipped   = 1'b0;
      end else begin
         rsp_data_in.centre_x  = cxo[31:0];
         rsp_data_in.centre_y  = cyo[31:0];
         rsp_data_in.valid_res = 1'b1;
         if (ch_ff[Last].dr.ovf || ch_ff[Last].dr.q[32]) begin
            rsp_data_in.radius  = 32'hFFFF_FFFF;
            rsp_data_in.clipped = 1'b1;
         end else begin
            rsp_data_in.radius  = ch_ff[Last].dr.q[31:0];
            rsp_data_in.clipped = cxo[32] | cyo[32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld    <= 1'b0;
         s2_ff.vld    <= 1'b0;
         s3_ff.vld    <= 1'b0;
         s4_ff.vld    <= 1'b0;
         s5_ff.vld    <= 1'b0;
         s6_ff.vld    <= 1'b0;
         s7_ff.vld    <= 1'b0;
         s8_ff.vld    <= 1'b0;
         s9_ff.vld    <= 1'b0;
         for (int i = 0; i <= Last; i++) begin
            ch_ff[i].vld <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         s4_ff        <= s4_in;
         s5_ff        <= s5_in;
         s6_ff        <= s6_in;
         s7_ff        <= s7_in;
         s8_ff        <= s8_in;
         s9_ff        <= s9_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

endmodule
